[hw/rtl/lssf_pkg.sv]
// Shared types, codes and defaults for the LED scan and flash sequencer.
package lssf_pkg;

    localparam int NUM_LEDS_DEF    = 10;
    localparam int FLASH_COUNT_DEF = 10;

    localparam int KIND_W  = 4;
    localparam int IDX_W   = 4;
    localparam int SPEED_W = 4;
    localparam int DWELL_W = 7;
    localparam int MODE_W  = 2;

    localparam logic [SPEED_W-1:0] MAX_SPEED  = 4'd9;
    localparam logic [DWELL_W-1:0] DWELL_BASE = 7'd100;

    localparam logic [KIND_W-1:0] KIND_TICK      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SET_SPEED = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INC_SPEED = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DEC_SPEED = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SCAN      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_FLASH     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_ALL_ON    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ALL_OFF   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_LED_ON    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LED_OFF   = 4'd9;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLASH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   led_index;
        logic [SPEED_W-1:0] speed_value;
    } item_t;

    typedef struct packed {
        logic               done;
        logic               busy;
        logic [SPEED_W-1:0] speed;
    } status_t;

endpackage

[hw/rtl/lssf_engine.sv]
// Sequencer state and next-state logic for one command or tick.
module lssf_engine #(
    parameter int NUM_LEDS    = lssf_pkg::NUM_LEDS_DEF,
    parameter int FLASH_COUNT = lssf_pkg::FLASH_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  lssf_pkg::item_t       item,
    output logic [NUM_LEDS-1:0]   leds,
    output lssf_pkg::status_t     status
);
    import lssf_pkg::*;

    localparam int SCAN_STEPS  = 2 * NUM_LEDS + 1;
    localparam int FLASH_STEPS = 2 * FLASH_COUNT;
    localparam int MAX_STEPS   = (SCAN_STEPS > FLASH_STEPS) ? SCAN_STEPS : FLASH_STEPS;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);

    localparam logic [STEP_W-1:0] SCAN_TOTAL  = STEP_W'(SCAN_STEPS);
    localparam logic [STEP_W-1:0] FLASH_TOTAL = STEP_W'(FLASH_STEPS);
    localparam logic [STEP_W-1:0] LED_LIMIT   = STEP_W'(NUM_LEDS);
    localparam logic [STEP_W-1:0] TURN_POINT  = STEP_W'(2 * NUM_LEDS);
    localparam logic [IDX_W:0]    IDX_LIMIT   = (IDX_W + 1)'(NUM_LEDS);

    logic [NUM_LEDS-1:0] lamps_reg,      lamps_next;
    logic [SPEED_W-1:0]  speed_reg,      speed_next;
    logic [MODE_W-1:0]   mode_reg,       mode_next;
    logic [STEP_W-1:0]   step_reg,       step_next;
    logic [DWELL_W-1:0]  dwell_left_reg, dwell_left_next;
    logic [DWELL_W-1:0]  dwell_len_reg,  dwell_len_next;

    logic                busy;
    logic                done;
    logic [DWELL_W-1:0]  speed_ext;
    logic [DWELL_W-1:0]  dwell_new;
    logic [DWELL_W-1:0]  dwell_dec;
    logic [STEP_W-1:0]   step_inc;
    logic [STEP_W-1:0]   step_total;

    function automatic logic [NUM_LEDS-1:0] pos_bit(input logic [STEP_W-1:0] pos);
        logic [NUM_LEDS-1:0] r;
        r = '0;
        if (pos < LED_LIMIT)
        begin
            r = NUM_LEDS'(1) << pos;
        end
        return r;
    endfunction

    function automatic logic [NUM_LEDS-1:0] idx_bit(input logic [IDX_W-1:0] idx);
        logic [NUM_LEDS-1:0] r;
        r = '0;
        if ({1'b0, idx} < IDX_LIMIT)
        begin
            r = NUM_LEDS'(1) << idx;
        end
        return r;
    endfunction

    function automatic logic [NUM_LEDS-1:0] step_lamps(
        input logic [MODE_W-1:0]   m,
        input logic [STEP_W-1:0]   k,
        input logic [NUM_LEDS-1:0] l
    );
        logic [NUM_LEDS-1:0] r;
        logic [STEP_W-1:0]   j;
        r = l;
        j = TURN_POINT - k;
        if (m == MODE_SCAN)
        begin
            if (k < LED_LIMIT)
            begin
                r = l | pos_bit(k);
                if (k != '0)
                begin
                    r = r & ~pos_bit(k - 1'b1);
                end
            end
            else if (k > LED_LIMIT)
            begin
                r = (l | pos_bit(j)) & ~pos_bit(j + 1'b1);
            end
        end
        else if (m == MODE_FLASH)
        begin
            r = k[0] ? '0 : '1;
        end
        return r;
    endfunction

    always_comb
    begin
        busy       = (mode_reg != MODE_IDLE);
        done       = 1'b0;
        speed_ext  = DWELL_W'(speed_reg);
        dwell_new  = DWELL_BASE - ((speed_ext << 3) + (speed_ext << 1));
        dwell_dec  = (dwell_left_reg != '0) ? dwell_left_reg - 1'b1 : dwell_left_reg;
        step_inc   = step_reg + 1'b1;
        step_total = (mode_reg == MODE_SCAN) ? SCAN_TOTAL : FLASH_TOTAL;

        lamps_next      = lamps_reg;
        speed_next      = speed_reg;
        mode_next       = mode_reg;
        step_next       = step_reg;
        dwell_left_next = dwell_left_reg;
        dwell_len_next  = dwell_len_reg;

        case (item.kind)
            KIND_TICK:
            begin
                if (busy)
                begin
                    dwell_left_next = dwell_dec;
                    if (dwell_dec == '0)
                    begin
                        if (step_inc >= step_total)
                        begin
                            mode_next = MODE_IDLE;
                            step_next = '0;
                            done      = 1'b1;
                        end
                        else
                        begin
                            step_next       = step_inc;
                            dwell_left_next = dwell_len_reg;
                            lamps_next      = step_lamps(mode_reg, step_inc, lamps_reg);
                        end
                    end
                end
            end
            KIND_SET_SPEED:
            begin
                speed_next = (item.speed_value > MAX_SPEED) ? MAX_SPEED : item.speed_value;
            end
            KIND_INC_SPEED:
            begin
                if (speed_reg < MAX_SPEED)
                begin
                    speed_next = speed_reg + 1'b1;
                end
            end
            KIND_DEC_SPEED:
            begin
                if (speed_reg != '0)
                begin
                    speed_next = speed_reg - 1'b1;
                end
            end
            KIND_SCAN, KIND_FLASH:
            begin
                if (!busy)
                begin
                    mode_next       = (item.kind == KIND_SCAN) ? MODE_SCAN : MODE_FLASH;
                    step_next       = '0;
                    dwell_len_next  = dwell_new;
                    dwell_left_next = dwell_new;
                    lamps_next      = step_lamps(mode_next, '0, lamps_reg);
                end
            end
            KIND_ALL_ON:
            begin
                if (!busy)
                begin
                    lamps_next = '1;
                end
            end
            KIND_ALL_OFF:
            begin
                if (!busy)
                begin
                    lamps_next = '0;
                end
            end
            KIND_LED_ON:
            begin
                if (!busy)
                begin
                    lamps_next = lamps_reg | idx_bit(item.led_index);
                end
            end
            KIND_LED_OFF:
            begin
                if (!busy)
                begin
                    lamps_next = lamps_reg & ~idx_bit(item.led_index);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamps_reg      <= '0;
            speed_reg      <= '0;
            mode_reg       <= MODE_IDLE;
            step_reg       <= '0;
            dwell_left_reg <= '0;
            dwell_len_reg  <= DWELL_BASE;
        end
        else if (step_en)
        begin
            lamps_reg      <= lamps_next;
            speed_reg      <= speed_next;
            mode_reg       <= mode_next;
            step_reg       <= step_next;
            dwell_left_reg <= dwell_left_next;
            dwell_len_reg  <= dwell_len_next;
        end
    end

    assign leds         = lamps_next;
    assign status.done  = done;
    assign status.busy  = (mode_next != MODE_IDLE);
    assign status.speed = speed_next;

endmodule

[hw/rtl/led_scan_flash_sequencer.sv]
// Top level of the LED scan and flash sequencer: input stage, engine, result stage.
//
// Slave stream (s_*): one transaction per command or 1 ms tick. tuser carries the
// command kind, tdata carries the LED index and the speed value.
// Master stream (m_*): exactly one result transaction per input transaction, in
// order, carrying the lamp register, the speed level, busy and done after the item.
// Flow: an accepted transaction is held in the input register, is evaluated by
// the engine and lands in the result register once that register is empty or
// draining, and its result is then offered from there.
// Throughput: one transaction per cycle while m_tready is high; the registered engine
// update of the sequencer state is the only loop.
// Reset: all lamps off, speed 0, no sequence running, latched dwell 100 ticks;
// both stages empty.
// Stall: while m_tready is low the result register holds, the input register
// still takes one more transaction, then s_tready drops until the result drains.
module led_scan_flash_sequencer #(
    parameter int NUM_LEDS    = lssf_pkg::NUM_LEDS_DEF,
    parameter int FLASH_COUNT = lssf_pkg::FLASH_COUNT_DEF,
    parameter int OUT_W       = ((NUM_LEDS + 6 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [3:0] led_index, [7:4] speed_value
    input  logic [3:0]       s_tuser,   // [3:0] kind
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // leds, speed (4), busy_res, done_res, zero pad
);
    import lssf_pkg::*;

    logic                in_valid_reg,  in_valid_next;
    item_t               in_item_reg;
    logic                out_valid_reg, out_valid_next;
    logic [NUM_LEDS-1:0] out_leds_reg;
    status_t             out_status_reg;

    logic                advance;
    logic                s_accept;
    item_t               s_item;
    logic [NUM_LEDS-1:0] eng_leds;
    status_t             eng_status;

    assign s_item.kind        = s_tuser[3:0];
    assign s_item.led_index   = s_tdata[3:0];
    assign s_item.speed_value = s_tdata[7:4];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    lssf_engine #(
        .NUM_LEDS    (NUM_LEDS),
        .FLASH_COUNT (FLASH_COUNT)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .leds    (eng_leds),
        .status  (eng_status)
    );

    always_comb
    begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_leds_reg   <= eng_leds;
            out_status_reg <= eng_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_status_reg.done, out_status_reg.busy,
                              out_status_reg.speed, out_leds_reg});

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg.done |-> !out_status_reg.busy)
        else $error("done reported while a sequence still runs");

    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg.speed <= MAX_SPEED)
        else $error("speed level above its limit");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage lost a pending transaction");

endmodule
